// ===== rtl/lsbse_pkg.sv =====
// Shared types and constants for the LSB payload extractor.
`timescale 1ns / 1ps

package lsbse_pkg;

   // Register widths and reset values
   localparam int HeaderWidth = 16;
   localparam int MagicLenWidth = 4;
   localparam int MagicWidth = 64;
   localparam int CsrDataWidth = 64;
   localparam int CsrIndexWidth = 2;

   localparam logic [HeaderWidth-1:0] HeaderReset = 16'd54;
   localparam logic [MagicLenWidth-1:0] MagicLenReset = 4'd2;
   localparam logic [MagicWidth-1:0] MagicReset = 64'd10787;
   localparam logic [MagicLenWidth-1:0] MagicLenMax = 4'd8;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_HEADER_BYTES = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MAGIC_LENGTH = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MAGIC_WORD = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_EXT = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Status codes
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_MAGIC = 3'd1;
   localparam logic [2:0] ST_NEG_EXT = 3'd2;
   localparam logic [2:0] ST_ZERO_EXT = 3'd3;
   localparam logic [2:0] ST_TRUNC = 3'd4;

   // Output queue
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   typedef enum logic [6:0] {
      PH_HEADER  = 7'b0000001,
      PH_MAGIC   = 7'b0000010,
      PH_EXTLEN  = 7'b0000100,
      PH_EXT     = 7'b0001000,
      PH_DATALEN = 7'b0010000,
      PH_DATA    = 7'b0100000,
      PH_DONE    = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic [2:0] status_code;
      logic       last;
   } result_type;

endpackage

// ===== rtl/lsb_stego_payload_extractor.sv =====
// Top level of the LSB payload extractor: bit gathering, decode and output queue.
`timescale 1ns / 1ps

// Takes one image byte per beat and, after skipping header_bytes bytes, packs bit 0
// of each byte (first bit most significant) into 8-bit characters and 32-bit lengths:
// magic word, extension length, extension characters, data length, data bytes, then
// one final status beat with last set. Each input byte is decoded in the cycle it is
// accepted and its zero, one or two results land in a 4-entry output queue that
// drains one beat per cycle unless stalled. It takes a byte every cycle while the queue
// holds at most two results, so it sustains one byte per cycle when the result side
// keeps up; req_stall rises only when three or more results wait. A byte with
// image_end set closes the image (status 4 if the decode had not finished) and rearms
// for the next image. The user must write registers only while idle (not enforced).
module lsb_stego_payload_extractor (
   input  logic                                  clock,
   input  logic                                  reset,
   // image byte beats
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_image_byte,
   input  logic                                  req_image_end,
   // result beats
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_out_byte,
   output logic [1:0]                            rsp_out_kind,
   output logic [2:0]                            rsp_status_code,
   output logic                                  rsp_last,
   // register writes
   input  logic                                  csr_write_en,
   input  logic [lsbse_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [lsbse_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import lsbse_pkg::*;

   // configuration registers
   logic [HeaderWidth-1:0]   header_bytes_ff;
   logic [MagicLenWidth-1:0] magic_length_ff;
   logic [MagicWidth-1:0]    magic_word_ff;

   // decode state
   phase_type              phase_ff, phase_in;
   logic [HeaderWidth-1:0] header_left_ff, header_left_in;
   logic [4:0]             bit_count_ff, bit_count_in;
   logic [31:0]            bit_shift_ff, bit_shift_in;
   logic [31:0]            item_count_ff, item_count_in;
   logic [31:0]            ext_length_ff, ext_length_in;
   logic [31:0]            data_remaining_ff, data_remaining_in;
   logic                   zero_seen_ff, zero_seen_in;

   // output queue
   result_type               queue_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntWidth-1:0] count_ff;

   // decode results of the current beat
   logic                   accept;
   logic                   pop;
   logic                   char_valid;
   logic [7:0]             char_byte;
   logic [1:0]             char_kind;
   logic                   fin_valid;
   logic [2:0]             fin_code;
   logic [31:0]            shifted;
   logic [31:0]            item;
   logic [31:0]            count_next;
   logic                   item_full;
   logic [MagicLenWidth-1:0] magic_len_eff;
   logic [7:0]             magic_expect;
   result_type             char_res, fin_res;
   result_type             push0, push1;
   logic [1:0]             push_n;

   assign accept = req_valid & ~req_stall;
   assign pop = rsp_valid & ~rsp_stall;

   // clamp magic length to 1..8
   always_comb begin
      if (magic_length_ff == '0) begin
         magic_len_eff = MagicLenWidth'(1);
      end else if (magic_length_ff > MagicLenMax) begin
         magic_len_eff = MagicLenMax;
      end else begin
         magic_len_eff = magic_length_ff;
      end
   end

   assign magic_expect = magic_word_ff[{item_count_ff[2:0], 3'b000} +: 8];
   assign shifted = {bit_shift_ff[30:0], req_image_byte[0]};
   assign item = shifted;
   assign count_next = item_count_ff + 32'd1;

   // decode one image byte
   always_comb begin
      phase_in          = phase_ff;
      header_left_in    = header_left_ff;
      bit_count_in      = bit_count_ff;
      bit_shift_in      = bit_shift_ff;
      item_count_in     = item_count_ff;
      ext_length_in     = ext_length_ff;
      data_remaining_in = data_remaining_ff;
      zero_seen_in      = zero_seen_ff;
      char_valid        = 1'b0;
      char_byte         = item[7:0];
      char_kind         = KIND_EXT;
      fin_valid         = 1'b0;
      fin_code          = ST_OK;
      item_full         = 1'b0;

      if (accept) begin
         // header skip: count down, and on reaching zero this byte already carries a bit
         if (phase_ff == PH_HEADER) begin
            if (header_left_ff != '0) begin
               header_left_in = header_left_ff - HeaderWidth'(1);
            end else begin
               phase_in = PH_MAGIC;
            end
         end

         if (phase_in != PH_HEADER && phase_in != PH_DONE) begin
            if (phase_in == PH_EXTLEN || phase_in == PH_DATALEN) begin
               item_full = (bit_count_ff == 5'd31);
            end else begin
               item_full = (bit_count_ff == 5'd7);
            end
            if (item_full) begin
               bit_shift_in = '0;
               bit_count_in = '0;
            end else begin
               bit_shift_in = shifted;
               bit_count_in = bit_count_ff + 5'd1;
            end
         end

         if (item_full) begin
            case (phase_in)
               PH_MAGIC: begin
                  zero_seen_in  = zero_seen_ff | (item[7:0] != magic_expect);
                  item_count_in = count_next;
                  if (count_next >= {28'd0, magic_len_eff}) begin
                     if (zero_seen_in) begin
                        fin_valid = 1'b1;
                        fin_code  = ST_MAGIC;
                        phase_in  = PH_DONE;
                     end else begin
                        phase_in      = PH_EXTLEN;
                        item_count_in = '0;
                     end
                  end
               end
               PH_EXTLEN: begin
                  ext_length_in = item;
                  if (item[31]) begin
                     fin_valid = 1'b1;
                     fin_code  = ST_NEG_EXT;
                     phase_in  = PH_DONE;
                  end else begin
                     item_count_in = '0;
                     zero_seen_in  = 1'b0;
                     phase_in      = (item == '0) ? PH_DATALEN : PH_EXT;
                  end
               end
               PH_EXT: begin
                  char_valid    = 1'b1;
                  char_kind     = KIND_EXT;
                  zero_seen_in  = zero_seen_ff | (item[7:0] == 8'd0);
                  item_count_in = count_next;
                  if (count_next == ext_length_ff) begin
                     if (zero_seen_in) begin
                        fin_valid = 1'b1;
                        fin_code  = ST_ZERO_EXT;
                        phase_in  = PH_DONE;
                     end else begin
                        phase_in = PH_DATALEN;
                     end
                  end
               end
               PH_DATALEN: begin
                  if (item[31] || item == '0) begin
                     fin_valid = 1'b1;
                     fin_code  = ST_OK;
                     phase_in  = PH_DONE;
                  end else begin
                     data_remaining_in = item;
                     phase_in          = PH_DATA;
                  end
               end
               PH_DATA: begin
                  char_valid        = 1'b1;
                  char_kind         = KIND_DATA;
                  data_remaining_in = data_remaining_ff - 32'd1;
                  if (data_remaining_ff == 32'd1) begin
                     fin_valid = 1'b1;
                     fin_code  = ST_OK;
                     phase_in  = PH_DONE;
                  end
               end
               default: begin
               end
            endcase
         end

         // image end: close out an unfinished decode, then rearm
         if (req_image_end) begin
            if (phase_in != PH_DONE) begin
               fin_valid = 1'b1;
               fin_code  = ST_TRUNC;
            end
            phase_in          = PH_HEADER;
            header_left_in    = header_bytes_ff;
            bit_count_in      = '0;
            bit_shift_in      = '0;
            item_count_in     = '0;
            ext_length_in     = '0;
            data_remaining_in = '0;
            zero_seen_in      = 1'b0;
         end
      end

      // a header_bytes write during header skip reloads the countdown
      if (csr_write_en && csr_index == CSR_HEADER_BYTES && phase_ff == PH_HEADER) begin
         header_left_in = csr_wdata[HeaderWidth-1:0];
      end
   end

   // order the results of this beat: character first, then status
   always_comb begin
      char_res.out_byte    = char_byte;
      char_res.out_kind    = char_kind;
      char_res.status_code = ST_OK;
      char_res.last        = 1'b0;
      fin_res.out_byte     = 8'd0;
      fin_res.out_kind     = KIND_STATUS;
      fin_res.status_code  = fin_code;
      fin_res.last         = 1'b1;
      push0  = char_valid ? char_res : fin_res;
      push1  = fin_res;
      push_n = {1'b0, char_valid} + {1'b0, fin_valid};
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_bytes_ff <= HeaderReset;
         magic_length_ff <= MagicLenReset;
         magic_word_ff   <= MagicReset;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_HEADER_BYTES: header_bytes_ff <= csr_wdata[HeaderWidth-1:0];
            CSR_MAGIC_LENGTH: magic_length_ff <= csr_wdata[MagicLenWidth-1:0];
            CSR_MAGIC_WORD:   magic_word_ff   <= csr_wdata[MagicWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HEADER;
         header_left_ff    <= HeaderReset;
         bit_count_ff      <= '0;
         bit_shift_ff      <= '0;
         item_count_ff     <= '0;
         ext_length_ff     <= '0;
         data_remaining_ff <= '0;
         zero_seen_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         header_left_ff    <= header_left_in;
         bit_count_ff      <= bit_count_in;
         bit_shift_ff      <= bit_shift_in;
         item_count_ff     <= item_count_in;
         ext_length_ff     <= ext_length_in;
         data_remaining_ff <= data_remaining_in;
         zero_seen_ff      <= zero_seen_in;
      end
   end

   // output queue payload: push up to two results per beat
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + QueuePtrWidth'(1)] <= push1;
      end
   end

   // output queue pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QueuePtrWidth'(push_n);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QueuePtrWidth'(1);
         end
         count_ff <= count_ff + QueueCntWidth'(push_n) - QueueCntWidth'(pop);
      end
   end

   // hold input whenever a two-result beat might not fit
   assign req_stall = (count_ff > QueueCntWidth'(QueueDepth - 2));

   assign rsp_valid       = (count_ff != '0);
   assign rsp_out_byte    = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_out_kind    = queue_ff[rd_ptr_ff].out_kind;
   assign rsp_status_code = queue_ff[rd_ptr_ff].status_code;
   assign rsp_last        = queue_ff[rd_ptr_ff].last;

endmodule

// ===== tb/sv/lsbse_tb_pkg.sv =====
// Decode predictor and result scoreboard for the LSB payload extractor testbench.
`timescale 1ns / 1ps

package lsbse_tb_pkg;

   import lsbse_pkg::*;

   // Register index that the block ignores
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE = 2'd3;

   // Magic length as the block applies it: 0 acts as 1, anything above 8 as 8
   function automatic int unsigned magic_chars(logic [MagicLenWidth-1:0] len);
      if (len == '0) return 1;
      if (len > MagicLenMax) return MagicLenMax;
      return len;
   endfunction

   class stego_decode_board;
      logic [HeaderWidth-1:0]   header_bytes;
      logic [MagicLenWidth-1:0] magic_length;
      logic [MagicWidth-1:0]    magic_word;

      phase_type              phase;
      logic [HeaderWidth-1:0] header_left;
      int unsigned            bit_count;
      logic [31:0]            bit_shift;
      logic [31:0]            item_count;
      logic [31:0]            ext_length;
      logic [31:0]            data_remaining;
      bit                     flagged;

      result_type  pending_results[$];
      int unsigned mismatch_count;
      int unsigned results_seen;
      int unsigned hidden_bits;

      function new();
         header_bytes   = HeaderReset;
         magic_length   = MagicLenReset;
         magic_word     = MagicReset;
         mismatch_count = 0;
         results_seen   = 0;
         hidden_bits    = 0;
         rearm();
      endfunction

      function void rearm();
         phase          = PH_HEADER;
         header_left    = header_bytes;
         bit_count      = 0;
         bit_shift      = '0;
         item_count     = '0;
         ext_length     = '0;
         data_remaining = '0;
         flagged        = 1'b0;
      endfunction

      function void write_reg(logic [CsrIndexWidth-1:0] index, logic [CsrDataWidth-1:0] value);
         case (index)
            CSR_HEADER_BYTES: begin
               header_bytes = value[HeaderWidth-1:0];
               if (phase == PH_HEADER) header_left = header_bytes;
            end
            CSR_MAGIC_LENGTH: magic_length = value[MagicLenWidth-1:0];
            CSR_MAGIC_WORD:   magic_word = value;
            default: ;
         endcase
      endfunction

      function void push_char(logic [1:0] kind, logic [7:0] value);
         result_type r;
         r = '{out_byte: value, out_kind: kind, status_code: ST_OK, last: 1'b0};
         pending_results.push_back(r);
      endfunction

      function void close_decode(logic [2:0] code);
         result_type r;
         r = '{out_byte: 8'd0, out_kind: KIND_STATUS, status_code: code, last: 1'b1};
         pending_results.push_back(r);
         phase = PH_DONE;
      endfunction

      function void take_item(logic [31:0] word);
         logic [7:0] want_char;
         case (phase)
            PH_MAGIC: begin
               want_char = magic_word[item_count[2:0]*8 +: 8];
               if (word[7:0] != want_char) flagged = 1'b1;
               item_count++;
               if (item_count >= magic_chars(magic_length)) begin
                  if (flagged) close_decode(ST_MAGIC);
                  else begin
                     phase      = PH_EXTLEN;
                     item_count = '0;
                  end
               end
            end
            PH_EXTLEN: begin
               ext_length = word;
               if (word[31]) close_decode(ST_NEG_EXT);
               else begin
                  item_count = '0;
                  flagged    = 1'b0;
                  phase      = (word == '0) ? PH_DATALEN : PH_EXT;
               end
            end
            PH_EXT: begin
               push_char(KIND_EXT, word[7:0]);
               if (word[7:0] == 8'd0) flagged = 1'b1;
               item_count++;
               if (item_count == ext_length) begin
                  if (flagged) close_decode(ST_ZERO_EXT);
                  else phase = PH_DATALEN;
               end
            end
            PH_DATALEN: begin
               if (word[31] || word == '0) close_decode(ST_OK);
               else begin
                  data_remaining = word;
                  phase          = PH_DATA;
               end
            end
            PH_DATA: begin
               push_char(KIND_DATA, word[7:0]);
               data_remaining--;
               if (data_remaining == '0) close_decode(ST_OK);
            end
            default: ;
         endcase
      endfunction

      // Advance the decode by one accepted image byte and queue what it yields
      function void note_image_byte(logic [7:0] image_byte, logic image_end);
         int unsigned width;
         logic [31:0] word;
         if (phase == PH_HEADER) begin
            if (header_left > 0) header_left--;
            else phase = PH_MAGIC;
         end
         if (phase != PH_HEADER && phase != PH_DONE) begin
            hidden_bits++;
            bit_shift = {bit_shift[30:0], image_byte[0]};
            bit_count++;
            width = (phase == PH_EXTLEN || phase == PH_DATALEN) ? 32 : 8;
            if (bit_count >= width) begin
               word      = bit_shift;
               bit_shift = '0;
               bit_count = 0;
               take_item(word);
            end
         end
         if (image_end) begin
            if (phase != PH_DONE) close_decode(ST_TRUNC);
            rearm();
         end
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatch_count++;
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      endtask

      task check_result(result_type got);
         result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected beat, out_byte", got.out_byte, 0);
            return;
         end
         want = pending_results.pop_front();
         if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
         if (got.out_kind !== want.out_kind)
            report_mismatch("out_kind", got.out_kind, want.out_kind);
         if (got.status_code !== want.status_code)
            report_mismatch("status_code", got.status_code, want.status_code);
         if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
      endtask

      task check_drained();
         if (pending_results.size() != 0)
            report_mismatch("beats never delivered, count", pending_results.size(), 0);
      endtask
   endclass

endpackage

// ===== tb/sv/tb_lsb_stego_payload_extractor.sv =====
// Top-level testbench for the LSB payload extractor: stimulus, idling and final verdict.
`timescale 1ns / 1ps

module tb_lsb_stego_payload_extractor;

   import lsbse_pkg::*;
   import lsbse_tb_pkg::*;

   localparam int CycleLimit  = 2_000_000;
   localparam int DrainCycles = 8;
   localparam int HoldCycles  = 160;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_image_byte = 8'd0;
   logic                     req_image_end = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [7:0]               rsp_out_byte;
   logic [1:0]               rsp_out_kind;
   logic [2:0]               rsp_status_code;
   logic                     rsp_last;
   logic                     csr_write_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   // Idle rates in percent; written by the stimulus process only
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   // Long receiver hold-offs asked for by the stimulus, served by the receiver
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;

   // Register values as the stimulus builder sees them
   logic [HeaderWidth-1:0]   cfg_header;
   logic [MagicLenWidth-1:0] cfg_magic_len;
   logic [MagicWidth-1:0]    cfg_magic_word;

   // Bytes of the image being built, sent in order
   logic [7:0] image_bytes[$];

   stego_decode_board extract_board;

   lsb_stego_payload_extractor dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_image_byte  (req_image_byte),
      .req_image_end   (req_image_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_status_code (rsp_status_code),
      .rsp_last        (rsp_last),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // Watchdog: give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Result side: check every accepted beat, then pick the stall for the next cycle.
   // A requested hold-off takes priority and is counted here, independent of the sender.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         extract_board.check_result({rsp_out_byte, rsp_out_kind, rsp_status_code, rsp_last});
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = HoldCycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one image byte, idling first at the current rate; return at the accepting edge.
   // Valid stays high on return, so the caller either offers the next beat right away
   // or drops valid in this same step.
   task automatic send_beat(logic [7:0] value, logic image_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_image_byte <= value;
      req_image_end  <= image_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      extract_board.note_image_byte(value, image_end);
   endtask

   // Send the built bytes; mark the last one as the image end when closing
   task automatic send_image(bit close);
      for (int i = 0; i < image_bytes.size(); i++)
         send_beat(image_bytes[i], close && (i == image_bytes.size() - 1));
      image_bytes.delete();
   endtask

   // Drop valid and hold until every expected beat has come, plus a settling margin
   task automatic drain();
      req_valid <= 1'b0;
      while (extract_board.pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] index, logic [CsrDataWidth-1:0] value);
      csr_index    <= index;
      csr_wdata    <= value;
      csr_write_en <= 1'b1;
      @(posedge clock);
      extract_board.write_reg(index, value);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_regs(logic [HeaderWidth-1:0] header, logic [MagicLenWidth-1:0] mlen,
                               logic [MagicWidth-1:0] magic);
      drain();
      write_reg(CSR_HEADER_BYTES, CsrDataWidth'(header));
      write_reg(CSR_MAGIC_LENGTH, CsrDataWidth'(mlen));
      write_reg(CSR_MAGIC_WORD, magic);
      cfg_header     = header;
      cfg_magic_len  = mlen;
      cfg_magic_word = magic;
   endtask

   // Favor the byte extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Raw bytes: header, noise or trailing junk
   task automatic push_raw(int unsigned count);
      for (int unsigned i = 0; i < count; i++) image_bytes.push_back(8'($urandom_range(255)));
   endtask

   // Hide a value first bit first; the upper seven bits of each carrier byte are noise
   task automatic push_bits(logic [31:0] value, int width);
      logic [6:0] upper;
      for (int i = width - 1; i >= 0; i--) begin
         upper = 7'($urandom_range(127));
         image_bytes.push_back({upper, value[i]});
      end
   endtask

   // Magic word from the current registers; optionally flip one bit of one character
   task automatic push_magic(bit corrupt);
      int unsigned count;
      int unsigned bad;
      logic [7:0]  c;
      count = magic_chars(cfg_magic_len);
      bad   = $urandom_range(count - 1);
      for (int unsigned i = 0; i < count; i++) begin
         c = cfg_magic_word[i*8 +: 8];
         if (corrupt && i == bad) c ^= 8'(1 << $urandom_range(7));
         push_bits(c, 8);
      end
   endtask

   // Extension length followed by count characters; a declared length above count truncates
   task automatic push_extension(logic [31:0] len, int unsigned count, bit with_zero);
      int unsigned zero_at;
      logic [7:0]  c;
      zero_at = (count > 0) ? $urandom_range(count - 1) : 0;
      push_bits(len, 32);
      for (int unsigned i = 0; i < count; i++) begin
         c = (with_zero && i == zero_at) ? 8'd0 : 8'($urandom_range(1, 255));
         push_bits(c, 8);
      end
   endtask

   task automatic push_data(logic [31:0] len, int unsigned count);
      push_bits(len, 32);
      for (int unsigned i = 0; i < count; i++) push_bits(pick_byte(), 8);
   endtask

   // Mostly small headers, now and then a longer one
   task automatic random_regs();
      logic [HeaderWidth-1:0] header;
      header = ($urandom_range(9) == 0) ? HeaderWidth'($urandom_range(300))
                                        : HeaderWidth'($urandom_range(12));
      program_regs(header, MagicLenWidth'($urandom_range(15)), {$urandom, $urandom});
      if ($urandom_range(4) == 0) write_reg(CSR_SPARE, {$urandom, $urandom});
   endtask

   // One image: mostly well formed with random content, the rest broken or noise
   task automatic random_image();
      int unsigned pick;
      int unsigned n_ext;
      int unsigned n_data;
      int unsigned cut;
      pick = $urandom_range(99);
      push_raw(cfg_header);
      if (pick >= 90) begin
         push_raw($urandom_range(1, 120));
      end else begin
         push_magic(pick >= 60 && pick < 70);
         if (pick >= 60 && pick < 70) begin
            push_raw($urandom_range(20));
         end else if (pick >= 70 && pick < 78) begin
            push_bits(32'h8000_0000 | $urandom, 32);
            push_raw($urandom_range(40));
         end else begin
            n_ext = $urandom_range(4);
            push_extension(n_ext, n_ext, $urandom_range(9) == 0);
            if ($urandom_range(19) == 0) begin
               push_data(32'h8000_0000 | $urandom, 0);
            end else begin
               n_data = $urandom_range(8);
               push_data(n_data, n_data);
            end
            push_raw($urandom_range(3));
            // Cut the image at a random length, which may fall in the header or keep every byte
            if (pick >= 78) begin
               cut = $urandom_range(1, image_bytes.size());
               while (image_bytes.size() > cut) void'(image_bytes.pop_back());
            end
         end
      end
      send_image(1'b1);
   endtask

   // Random images at one idle setting until enough hidden bits and beats have gone by
   task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, bit with_hold);
      int unsigned bits_start;
      int unsigned beats_start;
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
      random_regs();
      if (with_hold) begin
         // Stall the result side for a long stretch while a long payload streams in,
         // so the output queue fills and the block pushes back on the image bytes
         program_regs(0, 1, {$urandom, $urandom});
         hold_requests <= hold_requests + 1;
         push_magic(1'b0);
         push_extension(2, 2, 1'b0);
         push_data(12, 12);
         send_image(1'b1);
         drain();
      end
      bits_start  = extract_board.hidden_bits;
      beats_start = extract_board.results_seen;
      while (extract_board.hidden_bits - bits_start < 60 ||
             extract_board.results_seen - beats_start < 6) begin
         if ($urandom_range(3) == 0) random_regs();
         random_image();
      end
   endtask

   initial begin
      extract_board  = new();
      cfg_header     = HeaderReset;
      cfg_magic_len  = MagicLenReset;
      cfg_magic_word = MagicReset;
      repeat (3) @(posedge clock);
      reset         <= 1'b0;
      send_idle_pct <= 23;
      recv_idle_pct <= 64;

      // Reset register values: default header and two-character magic
      push_raw(cfg_header);
      push_magic(1'b0);
      push_extension(3, 3, 1'b0);
      push_data(4, 4);
      send_image(1'b1);

      // No header, full eight-character magic of all ones, empty extension
      program_regs(0, 8, '1);
      push_magic(1'b0);
      push_extension(0, 0, 1'b0);
      push_data(1, 1);
      send_image(1'b1);

      // Magic length zero acts as one; a zero character inside the extension
      program_regs(1, 0, '0);
      push_raw(1);
      push_magic(1'b0);
      push_extension(2, 2, 1'b1);
      send_image(1'b1);

      // Magic length above eight clamps; bad magic
      program_regs(2, 15, {$urandom, $urandom});
      push_raw(2);
      push_magic(1'b1);
      send_image(1'b1);

      // One-character magic for the rest of the directed images
      program_regs(2, 1, 64'h5A);

      // Negative extension length
      push_raw(2);
      push_magic(1'b0);
      push_bits(32'h8000_0000, 32);
      send_image(1'b1);

      // Zero data length, with junk after the decode is done
      push_raw(2);
      push_magic(1'b0);
      push_extension(1, 1, 1'b0);
      push_data(0, 0);
      push_raw(5);
      send_image(1'b1);

      // Data length of minus one ends cleanly right after the length
      push_raw(2);
      push_magic(1'b0);
      push_extension(0, 0, 1'b0);
      push_data(32'hFFFF_FFFF, 0);
      send_image(1'b1);

      // Largest lengths, image ends long before them
      push_raw(2);
      push_magic(1'b0);
      push_extension(32'h7FFF_FFFF, 2, 1'b0);
      send_image(1'b1);
      push_raw(2);
      push_magic(1'b0);
      push_extension(0, 0, 1'b0);
      push_data(32'h7FFF_FFFF, 3);
      send_image(1'b1);

      // Image that ends inside its header
      push_raw(1);
      send_image(1'b1);

      // Rewrite the header count during the skip: it reloads. Rewrite it again after the
      // magic: the running image is not affected. The spare index does nothing.
      program_regs(16'hFFFF, 1, 64'hA5);
      push_raw(10);
      send_image(1'b0);
      drain();
      write_reg(CSR_HEADER_BYTES, 3);
      cfg_header = 3;
      push_raw(3);
      push_magic(1'b0);
      send_image(1'b0);
      drain();
      write_reg(CSR_HEADER_BYTES, 16'd20);
      cfg_header = 16'd20;
      write_reg(CSR_SPARE, '1);
      push_extension(1, 1, 1'b0);
      push_data(2, 2);
      send_image(1'b1);

      // Next image picks up the header count written mid-decode
      push_raw(cfg_header);
      push_magic(1'b0);
      push_extension(0, 0, 1'b0);
      push_data(1, 1);
      send_image(1'b1);

      // Random part: sender idles lightly, receiver heavily; then swapped; then neither
      run_phase(23, 64, 1'b0);
      run_phase(64, 23, 1'b0);
      run_phase(0, 0, 1'b1);

      drain();
      extract_board.check_drained();
      if (extract_board.mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
